### design/trmh_pkg.sv
package trmh_pkg;

  localparam int XY_W       = 24;
  localparam int Z_W        = 32;
  localparam int CELL_W     = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int EFF_W      = 13;
  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 40;
  localparam int WIDE_W     = 64;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_DRAW  = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;

endpackage

### design/trmh_ram.sv
module trmh_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/triangle_raster_max_height.sv
// Max-height triangle rasterizer over a GRID_W x GRID_H cell grid. Commands arrive on in_tuser
// (draw, read cell, clear); each command gives exactly one result transfer. Heights and filled
// flags live in one synchronous RAM; every covered cell gets a read-modify-write that keeps the
// larger height. All multiplies and divides go through one shift-add multiplier (one multiplier
// bit per cycle) and one 64-step restoring divider. After reset a clearing pass over every cell
// runs before the first input is taken. A draw sorts and checks the vertices, then per covered
// row evaluates the edges and sets up the span with multiplies and divides, then runs one
// divide and a read-modify-write per covered cell. Input is taken one command at a time; a
// finished result waits in the output register while the next command is accepted.
module triangle_raster_max_height
  import trmh_pkg::*;
#(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z,
  // read_col, read_row, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cell_height, drew_any, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // cell_empty
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int NCELLS = GRID_W * GRID_H;
  localparam int AW     = $clog2(NCELLS);
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  localparam int RAM_W  = Z_W + 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_SORT = 5'd2;
  localparam logic [4:0] S_CHK  = 5'd3;
  localparam logic [4:0] S_ROW  = 5'd4;
  localparam logic [4:0] S_E0   = 5'd5;
  localparam logic [4:0] S_E1   = 5'd6;
  localparam logic [4:0] S_E2   = 5'd7;
  localparam logic [4:0] S_E3   = 5'd8;
  localparam logic [4:0] S_F0   = 5'd9;
  localparam logic [4:0] S_F1   = 5'd10;
  localparam logic [4:0] S_F2   = 5'd11;
  localparam logic [4:0] S_F3   = 5'd12;
  localparam logic [4:0] S_F4   = 5'd13;
  localparam logic [4:0] S_C0   = 5'd14;
  localparam logic [4:0] S_C1   = 5'd15;
  localparam logic [4:0] S_NROW = 5'd16;
  localparam logic [4:0] S_RD0  = 5'd17;
  localparam logic [4:0] S_RD1  = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;
  localparam logic [4:0] S_MUL  = 5'd20;
  localparam logic [4:0] S_DIV  = 5'd21;
  localparam logic [4:0] S_DFIX = 5'd22;

  localparam logic signed [WIDE_W-1:0] Z_MAX = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] Z_MIN = -64'sd2147483648;

  logic [4:0] state_r, ret_r;
  logic       clr_init_r;
  logic [AW-1:0] clr_addr_r;

  logic [CFG_W-1:0] cols_r, rows_r;

  cmd_t                     cmd_r;
  logic [CELL_W-1:0]        rcol_r, rrow_r;
  logic signed [XY_W-1:0]   px_r [3];
  logic signed [XY_W-1:0]   py_r [3];
  logic signed [Z_W-1:0]    pz_r [3];

  logic signed [WIDE_W-1:0] mul_a_r, mul_acc_r;
  logic [WIDE_W-1:0]        mul_b_r;
  logic [WIDE_W-1:0]        div_rem_r, div_quo_r, div_den_r;
  logic [6:0]               div_cnt_r;
  logic                     div_neg_r;

  logic [1:0]               ek_r;
  logic                     short_r;
  logic signed [WIDE_W-1:0] p1_r, xa_r, za_r, xb_r, zb_r;
  logic signed [WIDE_W-1:0] den_r, qd_r, rd_r, acc_p_r, acc_r_r, t0_r;
  logic [XW-1:0]            x_r, bx_r;
  logic [YW-1:0]            y_r, by_r;
  logic [AW-1:0]            row_base_r;
  logic                     drew_r;

  logic                     out_valid_r;
  logic signed [Z_W-1:0]    res_h_r, out_h_r;
  logic                     res_e_r, res_d_r, out_e_r, out_d_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  logic [EFF_W-1:0] nx, ny;

  always_comb begin
    nx = (cols_r == '0) ? EFF_W'(1) :
         (EFF_W'(cols_r) > EFF_W'(GRID_W)) ? EFF_W'(GRID_W) : EFF_W'(cols_r);
    ny = (rows_r == '0) ? EFF_W'(1) :
         (EFF_W'(rows_r) > EFF_W'(GRID_H)) ? EFF_W'(GRID_H) : EFF_W'(rows_r);
  end

  // vertex sort by y, three compare-exchanges, equal y values are not swapped
  logic signed [XY_W-1:0] sx [3];
  logic signed [XY_W-1:0] sy [3];
  logic signed [Z_W-1:0]  sz [3];

  always_comb begin
    logic signed [XY_W-1:0] tx, ty;
    logic signed [Z_W-1:0]  tz;
    tx = '0;
    ty = '0;
    tz = '0;
    sx = px_r;
    sy = py_r;
    sz = pz_r;
    if (sy[1] < sy[0]) begin
      tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
      ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
      tz = sz[0]; sz[0] = sz[1]; sz[1] = tz;
    end
    if (sy[2] < sy[0]) begin
      tx = sx[0]; sx[0] = sx[2]; sx[2] = tx;
      ty = sy[0]; sy[0] = sy[2]; sy[2] = ty;
      tz = sz[0]; sz[0] = sz[2]; sz[2] = tz;
    end
    if (sy[2] < sy[1]) begin
      tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
      ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
      tz = sz[1]; sz[1] = sz[2]; sz[2] = tz;
    end
  end

  // triangle checks and row range
  logic signed [XY_W-1:0] xmin, xmax;
  logic signed [XY_W+1:0] ay_w, by_w, ay_c, by_c, nym1_w;
  logic                   tri_reject, rows_empty;

  always_comb begin
    xmin = px_r[0];
    xmax = px_r[0];
    for (int i = 1; i < 3; i++) begin
      if (px_r[i] < xmin) xmin = px_r[i];
      if (px_r[i] > xmax) xmax = px_r[i];
    end
    tri_reject = (py_r[0] >= py_r[2]) || (xmin >= xmax) || (py_r[2] < 0) ||
                 ((XY_W+2)'(py_r[0]) >= $signed((XY_W+2)'({ny, 8'b0}))) ||
                 (xmax < 0) ||
                 ((XY_W+2)'(xmin) >= $signed((XY_W+2)'({nx, 8'b0})));
    ay_w   = ((XY_W+2)'(py_r[0]) + (XY_W+2)'(255)) >>> 8;
    by_w   = (XY_W+2)'(py_r[2]) >>> 8;
    nym1_w = $signed((XY_W+2)'(ny)) - (XY_W+2)'(1);
    ay_c   = (ay_w < 0) ? '0 : ay_w;
    by_c   = (by_w > nym1_w) ? nym1_w : by_w;
    rows_empty = ay_c > by_c;
  end

  // edge endpoint selection
  logic [1:0]               i0, i1;
  logic signed [WIDE_W-1:0] e_s, e_e, e_ys, e_dy, y256;
  logic                     cond01, cond12;

  always_comb begin
    i0 = ek_r[1] ? (short_r ? 2'd1 : 2'd0) : 2'd0;
    i1 = ek_r[1] ? (short_r ? 2'd2 : 2'd1) : 2'd2;
    e_s  = ek_r[0] ? WIDE_W'(pz_r[i0]) : WIDE_W'(px_r[i0]);
    e_e  = ek_r[0] ? WIDE_W'(pz_r[i1]) : WIDE_W'(px_r[i1]);
    e_ys = WIDE_W'(py_r[i0]);
    e_dy = WIDE_W'(py_r[i1]) - e_ys;
    y256 = $signed(WIDE_W'({y_r, 8'b0}));
    cond01 = (y256 <= WIDE_W'(py_r[1])) && (py_r[1] > py_r[0]);
    cond12 = py_r[2] > py_r[1];
  end

  // span range on the current row
  logic signed [WIDE_W-1:0] ax_w, bx_w, ax_c, bx_c, nxm1, t0_w;

  always_comb begin
    ax_w = (xa_r + 64'sd65535) >>> 16;
    bx_w = xb_r >>> 16;
    nxm1 = $signed(WIDE_W'(nx)) - 64'sd1;
    ax_c = (ax_w < 0) ? '0 : ax_w;
    bx_c = (bx_w > nxm1) ? nxm1 : bx_w;
    t0_w = (ax_c <<< 16) - xa_r;
  end

  // cell height and compare
  logic signed [WIDE_W-1:0] z_w, z_c;
  logic                     cell_wr;

  always_comb begin
    z_w = za_r + acc_p_r + $signed(div_quo_r);
    z_c = (z_w > Z_MAX) ? Z_MAX : (z_w < Z_MIN) ? Z_MIN : z_w;
    cell_wr = !ram_rdata[Z_W] || ($signed(ram_rdata[Z_W-1:0]) < $signed(z_c[Z_W-1:0]));
  end

  // divider step
  logic [WIDE_W:0]   div_trial;
  logic              div_bit;
  logic [WIDE_W-1:0] div_rem_step;

  always_comb begin
    div_trial = {div_rem_r, div_quo_r[WIDE_W-1]};
    div_bit   = div_trial >= {1'b0, div_den_r};
    div_rem_step = div_bit ? WIDE_W'(div_trial - {1'b0, div_den_r}) : div_trial[WIDE_W-1:0];
  end

  logic              rd_in_range;
  logic [AW-1:0]     rd_addr;

  always_comb begin
    rd_in_range = (EFF_W'(rcol_r) < nx) && (EFF_W'(rrow_r) < ny);
    rd_addr     = AW'(32'(rrow_r) * GRID_W + 32'(rcol_r));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = row_base_r + AW'(x_r);
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_C0: begin
        ram_re = 1'b1;
      end
      S_C1: begin
        ram_we    = cell_wr;
        ram_waddr = row_base_r + AW'(x_r);
        ram_wdata = {1'b1, z_c[Z_W-1:0]};
      end
      S_RD0: begin
        ram_re    = rd_in_range;
        ram_raddr = rd_addr;
      end
      default: begin
      end
    endcase
  end

  trmh_ram #(
    .WIDTH(RAM_W),
    .DEPTH(NCELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_d_r, out_h_r};
  assign out_tuser  = out_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_init_r  <= 1'b1;
      clr_addr_r  <= '0;
      cols_r      <= COLS_RESET;
      rows_r      <= ROWS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_COLS) cols_r <= cfg_data;
        if (cfg_index == REG_ROWS) rows_r <= cfg_data;
      end
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r  <= in_tuser;
            px_r[0] <= in_tdata[23:0];
            py_r[0] <= in_tdata[47:24];
            pz_r[0] <= in_tdata[79:48];
            px_r[1] <= in_tdata[103:80];
            py_r[1] <= in_tdata[127:104];
            pz_r[1] <= in_tdata[159:128];
            px_r[2] <= in_tdata[183:160];
            py_r[2] <= in_tdata[207:184];
            pz_r[2] <= in_tdata[239:208];
            rcol_r <= in_tdata[245:240];
            rrow_r <= in_tdata[251:246];
            res_h_r <= '0;
            res_e_r <= 1'b0;
            res_d_r <= 1'b0;
            drew_r  <= 1'b0;
            clr_addr_r <= '0;
            clr_init_r <= 1'b0;
            case (in_tuser)
              CMD_DRAW:  state_r <= S_SORT;
              CMD_READ:  state_r <= S_RD0;
              CMD_CLEAR: state_r <= S_CLR;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(NCELLS - 1)) begin
            state_r <= clr_init_r ? S_IDLE : S_DONE;
          end
        end
        S_SORT: begin
          px_r <= sx;
          py_r <= sy;
          pz_r <= sz;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (tri_reject || rows_empty) begin
            state_r <= S_DONE;
          end else begin
            y_r        <= YW'(ay_c);
            by_r       <= YW'(by_c);
            row_base_r <= AW'(32'(ay_c) * GRID_W);
            state_r    <= S_ROW;
          end
        end
        S_ROW: begin
          ek_r    <= 2'd0;
          short_r <= !cond01;
          state_r <= (cond01 || cond12) ? S_E0 : S_NROW;
        end
        S_E0: begin
          mul_a_r   <= e_s;
          mul_b_r   <= e_dy;
          mul_acc_r <= '0;
          ret_r     <= S_E1;
          state_r   <= S_MUL;
        end
        S_E1: begin
          p1_r      <= mul_acc_r;
          mul_a_r   <= e_e - e_s;
          mul_b_r   <= y256 - e_ys;
          mul_acc_r <= '0;
          ret_r     <= S_E2;
          state_r   <= S_MUL;
        end
        S_E2: begin
          logic signed [WIDE_W-1:0] num;
          num = p1_r + mul_acc_r;
          if (!ek_r[0]) num = num <<< 8;
          div_den_r <= e_dy;
          div_neg_r <= num[WIDE_W-1];
          div_quo_r <= num[WIDE_W-1] ? -num : num;
          div_rem_r <= '0;
          div_cnt_r <= 7'd64;
          ret_r     <= S_E3;
          state_r   <= S_DIV;
        end
        S_E3: begin
          case (ek_r)
            2'd0:    xa_r <= div_quo_r;
            2'd1:    za_r <= div_quo_r;
            2'd2:    xb_r <= div_quo_r;
            default: zb_r <= div_quo_r;
          endcase
          ek_r    <= ek_r + 2'd1;
          state_r <= (ek_r == 2'd3) ? S_F0 : S_E0;
        end
        S_F0: begin
          if (xb_r < xa_r) begin
            xa_r <= xb_r;
            xb_r <= xa_r;
            za_r <= zb_r;
            zb_r <= za_r;
          end
          state_r <= S_F1;
        end
        S_F1: begin
          logic signed [WIDE_W-1:0] dz;
          dz = zb_r - za_r;
          if (xb_r == xa_r) begin
            state_r <= S_NROW;
          end else begin
            den_r     <= xb_r - xa_r;
            div_den_r <= xb_r - xa_r;
            div_neg_r <= dz[WIDE_W-1];
            div_quo_r <= dz[WIDE_W-1] ? -dz : dz;
            div_rem_r <= '0;
            div_cnt_r <= 7'd64;
            ret_r     <= S_F2;
            state_r   <= S_DIV;
          end
        end
        S_F2: begin
          qd_r <= div_quo_r;
          rd_r <= div_rem_r;
          if (ax_c > bx_c) begin
            state_r <= S_NROW;
          end else begin
            x_r       <= XW'(ax_c);
            bx_r      <= XW'(bx_c);
            t0_r      <= t0_w;
            mul_a_r   <= div_quo_r;
            mul_b_r   <= t0_w;
            mul_acc_r <= '0;
            ret_r     <= S_F3;
            state_r   <= S_MUL;
          end
        end
        S_F3: begin
          acc_p_r   <= mul_acc_r;
          mul_a_r   <= rd_r;
          mul_b_r   <= t0_r;
          mul_acc_r <= '0;
          ret_r     <= S_F4;
          state_r   <= S_MUL;
        end
        S_F4: begin
          acc_r_r <= mul_acc_r;
          state_r <= S_C0;
        end
        S_C0: begin
          div_den_r <= den_r;
          div_neg_r <= 1'b0;
          div_quo_r <= acc_r_r;
          div_rem_r <= '0;
          div_cnt_r <= 7'd64;
          ret_r     <= S_C1;
          state_r   <= S_DIV;
        end
        S_C1: begin
          if (cell_wr) drew_r <= 1'b1;
          acc_p_r <= acc_p_r + (qd_r <<< 16);
          acc_r_r <= acc_r_r + (rd_r <<< 16);
          x_r     <= x_r + XW'(1);
          state_r <= (x_r == bx_r) ? S_NROW : S_C0;
        end
        S_NROW: begin
          if (y_r == by_r) begin
            res_d_r <= drew_r;
            state_r <= S_DONE;
          end else begin
            y_r        <= y_r + YW'(1);
            row_base_r <= row_base_r + AW'(GRID_W);
            state_r    <= S_ROW;
          end
        end
        S_RD0: begin
          res_e_r <= 1'b1;
          state_r <= rd_in_range ? S_RD1 : S_DONE;
        end
        S_RD1: begin
          res_e_r <= !ram_rdata[Z_W];
          res_h_r <= ram_rdata[Z_W] ? ram_rdata[Z_W-1:0] : '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_h_r     <= res_h_r;
            out_e_r     <= res_e_r;
            out_d_r     <= res_d_r || (cmd_r == CMD_DRAW && drew_r);
            state_r     <= S_IDLE;
          end
        end
        S_MUL: begin
          if (mul_b_r == '0) begin
            state_r <= ret_r;
          end else begin
            if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
            mul_a_r <= mul_a_r <<< 1;
            mul_b_r <= mul_b_r >> 1;
          end
        end
        S_DIV: begin
          div_rem_r <= div_rem_step;
          div_quo_r <= {div_quo_r[WIDE_W-2:0], div_bit};
          div_cnt_r <= div_cnt_r - 7'd1;
          if (div_cnt_r == 7'd1) state_r <= S_DFIX;
        end
        S_DFIX: begin
          if (div_neg_r) begin
            if (div_rem_r != '0) begin
              div_quo_r <= ~div_quo_r;
              div_rem_r <= div_den_r - div_rem_r;
            end else begin
              div_quo_r <= -div_quo_r;
            end
          end
          state_r <= ret_r;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
